// File: rtl/cfa_pkg.sv
package cfa_pkg;

    // Default build sizes.
    localparam int MAX_FRAMES_DEF = 16384;
    localparam int FPW_DEF        = 4;

    // Fixed field widths.
    localparam int FRAME_W  = 20;
    localparam int COUNT_W  = 15;
    localparam int STATUS_W = 3;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Reset value of the pool size register.
    localparam logic [COUNT_W-1:0] POOL_RESET = 15'd16384;

    // Register indexes on the configuration port.
    localparam logic [1:0] RG_BASE    = 2'd0;
    localparam logic [1:0] RG_POOL    = 2'd1;
    localparam logic [1:0] RG_RESERVE = 2'd2;

    // Per-frame map codes.
    localparam logic [1:0] FS_FREE  = 2'd0;
    localparam logic [1:0] FS_ALLOC = 2'd1;
    localparam logic [1:0] FS_HEAD  = 2'd2;
    localparam logic [1:0] FS_INACC = 2'd3;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_REL   = 2'd1,
        K_MARK  = 2'd2,
        K_INIT  = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_NORUN   = 3'd2,
        ST_NOTHEAD = 3'd3,
        ST_RANGE   = 3'd4
    } t_status;

    // What a map walk does with each word.
    typedef enum logic [1:0] {
        MD_SCAN  = 2'd0,
        MD_MARKA = 2'd1,
        MD_REL   = 2'd2,
        MD_MARKI = 2'd3
    } t_mode;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  prep;
        logic  rd;
        logic  ev;
        logic  clr;
        logic  init_fill;
        logic  out_load;
        t_mode mode;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  pre_done;
        logic  pre_init;
        t_mode pre_mode;
        logic  ev_done;
        logic  found;
        logic  clr_last;
    } t_stat;

endpackage

// File: rtl/cfa_dpath.sv
module cfa_dpath #(
    parameter int MAX_FRAMES      = cfa_pkg::MAX_FRAMES_DEF,
    parameter int FRAMES_PER_WORD = cfa_pkg::FPW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfa_pkg::t_cmd                 i_cmd,
    output cfa_pkg::t_stat                o_stat,
    input  logic [cfa_pkg::FRAME_W-1:0]   i_base,
    input  logic [cfa_pkg::COUNT_W-1:0]   i_pool,
    input  logic                          i_reserve,
    input  logic [1:0]                    i_kind,
    input  logic [cfa_pkg::FRAME_W-1:0]   i_frame_no,
    input  logic [cfa_pkg::COUNT_W-1:0]   i_count,
    output logic [cfa_pkg::STATUS_W-1:0]  o_status,
    output logic [cfa_pkg::FRAME_W-1:0]   o_first_frame,
    output logic [cfa_pkg::COUNT_W-1:0]   o_freed,
    output logic [cfa_pkg::COUNT_W-1:0]   o_free_left
);
    import cfa_pkg::*;

    localparam int NW    = MAX_FRAMES / FRAMES_PER_WORD;
    localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int WW    = 2 * FRAMES_PER_WORD;
    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int XW    = CW + 1;
    localparam int SH    = 24;
    localparam int RECIP = (1 << SH) / FRAMES_PER_WORD;

    logic [WW-1:0]       mem [NW];
    logic [WW-1:0]       r_rd;

    t_kind               r_kind;
    logic [FRAME_W-1:0]  r_fno;
    logic [COUNT_W-1:0]  r_cnt;
    logic [XW-1:0]       r_off;
    logic [AW-1:0]       r_w;
    logic [XW-1:0]       r_fb;
    logic [CW-1:0]       r_run;
    logic [XW-1:0]       r_start;
    logic [AW-1:0]       r_sw;
    logic [XW-1:0]       r_sfb;
    logic [CW-1:0]       r_acc;
    logic                r_act;
    logic [CW-1:0]       r_free;
    logic [CW-1:0]       r_freedv;
    t_status             r_status;
    logic [FRAME_W-1:0]  r_first;
    logic [CW-1:0]       r_clamp;
    logic [CW-1:0]       r_q0;

    logic [CW-1:0]       clamp_c;
    logic [CW-1:0]       size;
    logic [31:0]         prod;
    logic [FRAME_W-1:0]  off20;
    logic                below;
    t_status             pre_st;

    logic [WW-1:0]       word;
    logic [CW-1:0]       run;
    logic [XW-1:0]       start;
    logic [AW-1:0]       sw;
    logic [XW-1:0]       sfb;
    logic [CW-1:0]       acc;
    logic                act;
    logic                found;
    logic                hfail;
    logic                done;
    logic [31:0]         n_fb;

    function automatic logic [CW-1:0] count_down(input logic [CW-1:0] f, input logic [CW-1:0] n);
        count_down = (n > f) ? '0 : f - n;
    endfunction

    // Usable pool size: clamped and rounded down to whole map words.
    always_comb begin
        clamp_c = (32'(i_pool) > 32'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(i_pool);
        prod    = 32'(r_q0) * 32'(FRAMES_PER_WORD);
        if (32'(r_clamp) - prod >= 32'(FRAMES_PER_WORD)) begin
            size = CW'(prod + 32'(FRAMES_PER_WORD));
        end else begin
            size = CW'(prod);
        end
    end

    // Reciprocal quotient stage; the estimate is low by at most one word.
    always_ff @(posedge i_clk) begin
        r_clamp <= clamp_c;
        r_q0    <= CW'((48'(clamp_c) * 48'(RECIP)) >> SH);
    end

    // Up-front checks that decide an item before any map access.
    always_comb begin
        below           = r_fno < i_base;
        off20           = r_fno - i_base;
        o_stat.pre_done = 1'b0;
        o_stat.pre_init = 1'b0;
        o_stat.pre_mode = MD_SCAN;
        pre_st          = ST_OK;
        unique case (r_kind)
            K_ALLOC: begin
                if (r_cnt == '0) begin
                    o_stat.pre_done = 1'b1;
                    pre_st          = ST_NORUN;
                end else if (32'(r_cnt) > 32'(r_free)) begin
                    o_stat.pre_done = 1'b1;
                    pre_st          = ST_FEW;
                end else if (size == '0) begin
                    o_stat.pre_done = 1'b1;
                    pre_st          = ST_NORUN;
                end
            end
            K_REL: begin
                if (below || 32'(off20) >= 32'(size)) begin
                    o_stat.pre_done = 1'b1;
                    pre_st          = ST_RANGE;
                end else begin
                    o_stat.pre_mode = MD_REL;
                end
            end
            K_MARK: begin
                if (below || 32'(off20) > 32'(size)
                        || 32'(r_cnt) > 32'(size) - 32'(off20)) begin
                    o_stat.pre_done = 1'b1;
                    pre_st          = ST_RANGE;
                end else if (r_cnt == '0) begin
                    o_stat.pre_done = 1'b1;
                end else begin
                    o_stat.pre_mode = MD_MARKI;
                end
            end
            K_INIT: begin
                o_stat.pre_init = 1'b1;
            end
            default: begin
                o_stat.pre_done = 1'b1;
            end
        endcase
    end

    // Per-word processing of the registered map word.
    always_comb begin
        word  = r_rd;
        run   = r_run;
        start = r_start;
        sw    = r_sw;
        sfb   = r_sfb;
        acc   = r_acc;
        act   = r_act;
        found = 1'b0;
        hfail = 1'b0;
        for (int j = 0; j < FRAMES_PER_WORD; j++) begin
            unique case (i_cmd.mode)
                MD_SCAN: begin
                    if (!found) begin
                        if (r_rd[2*j +: 2] != FS_FREE) begin
                            run = '0;
                        end else begin
                            if (run == '0) begin
                                start = XW'(32'(r_fb) + 32'(j));
                                sw    = r_w;
                                sfb   = r_fb;
                            end
                            run = run + 1'b1;
                            if (32'(run) == 32'(r_cnt)) begin
                                found = 1'b1;
                            end
                        end
                    end
                end
                MD_MARKA: begin
                    if (32'(r_fb) + 32'(j) >= 32'(r_start)
                            && 32'(r_fb) + 32'(j) < 32'(r_start) + 32'(r_cnt)) begin
                        word[2*j +: 2] = (32'(r_fb) + 32'(j) == 32'(r_start)) ?
                                         FS_HEAD : FS_ALLOC;
                    end
                end
                MD_REL: begin
                    if (32'(r_fb) + 32'(j) == 32'(r_off)) begin
                        if (r_rd[2*j +: 2] != FS_HEAD) begin
                            hfail = 1'b1;
                            act   = 1'b0;
                        end else begin
                            word[2*j +: 2] = FS_FREE;
                            acc            = CW'(1);
                        end
                    end else if (32'(r_fb) + 32'(j) > 32'(r_off) && act) begin
                        if (r_rd[2*j +: 2] == FS_ALLOC) begin
                            word[2*j +: 2] = FS_FREE;
                            acc            = acc + 1'b1;
                        end else begin
                            act = 1'b0;
                        end
                    end
                end
                MD_MARKI: begin
                    if (32'(r_fb) + 32'(j) >= 32'(r_off)
                            && 32'(r_fb) + 32'(j) < 32'(r_off) + 32'(r_cnt)) begin
                        if (r_rd[2*j +: 2] == FS_FREE) begin
                            acc = acc + 1'b1;
                        end
                        word[2*j +: 2] = FS_INACC;
                    end
                end
                default: begin
                end
            endcase
        end
        n_fb = 32'(r_fb) + 32'(FRAMES_PER_WORD);
        unique case (i_cmd.mode)
            MD_SCAN:  done = found || n_fb >= 32'(size);
            MD_MARKA: done = n_fb >= 32'(r_start) + 32'(r_cnt);
            MD_REL:   done = hfail || (n_fb > 32'(r_off) && !act) || n_fb >= 32'(size);
            MD_MARKI: done = n_fb >= 32'(r_off) + 32'(r_cnt);
            default:  done = 1'b1;
        endcase
        o_stat.ev_done  = done;
        o_stat.found    = found;
        o_stat.clr_last = r_w == AW'(NW - 1);
    end

    // Frame map: one read or one write per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= mem[r_w];
        end
        if (i_cmd.clr) begin
            if (i_cmd.init_fill && r_w == '0 && i_reserve && size != '0) begin
                mem[r_w] <= WW'(FS_HEAD);
            end else begin
                mem[r_w] <= '0;
            end
        end else if (i_cmd.ev && i_cmd.mode != MD_SCAN) begin
            mem[r_w] <= word;
        end
    end

    // Walk control and running counts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= '0;
            r_free <= CW'(MAX_FRAMES);
        end else if (i_cmd.load) begin
            r_w <= '0;
        end else if (i_cmd.clr) begin
            if (o_stat.clr_last) begin
                r_w <= '0;
                if (i_cmd.init_fill) begin
                    r_free <= (i_reserve && size != '0) ? size - 1'b1 : size;
                end
            end else begin
                r_w <= r_w + 1'b1;
            end
        end else if (i_cmd.ev) begin
            if (i_cmd.mode == MD_SCAN && found) begin
                r_w <= sw;
            end else begin
                r_w <= r_w + 1'b1;
            end
            if (done) begin
                unique case (i_cmd.mode)
                    MD_SCAN: begin
                    end
                    MD_MARKA: r_free <= count_down(r_free, CW'(r_cnt));
                    MD_REL: begin
                        if (!hfail) begin
                            r_free <= (32'(r_free) + 32'(acc) > 32'(MAX_FRAMES)) ?
                                      CW'(MAX_FRAMES) : CW'(32'(r_free) + 32'(acc));
                        end
                    end
                    MD_MARKI: r_free <= count_down(r_free, acc);
                    default: begin
                    end
                endcase
            end
        end
    end

    // Item payload and per-item working values.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= t_kind'(i_kind);
            r_fno    <= i_frame_no;
            r_cnt    <= i_count;
            r_fb     <= '0;
            r_run    <= '0;
            r_acc    <= '0;
            r_act    <= 1'b1;
            r_status <= ST_OK;
            r_first  <= '0;
            r_freedv <= '0;
        end else if (i_cmd.prep) begin
            r_status <= pre_st;
            r_off    <= XW'(off20);
        end else if (i_cmd.ev) begin
            r_run   <= run;
            r_start <= start;
            r_sw    <= sw;
            r_sfb   <= sfb;
            r_acc   <= acc;
            r_act   <= act;
            r_fb    <= (i_cmd.mode == MD_SCAN && found) ? sfb : XW'(n_fb);
            if (done) begin
                unique case (i_cmd.mode)
                    MD_SCAN: begin
                        if (!found) begin
                            r_status <= ST_NORUN;
                        end
                    end
                    MD_MARKA: r_first <= i_base + FRAME_W'(r_start);
                    MD_REL: begin
                        if (hfail) begin
                            r_status <= ST_NOTHEAD;
                        end else begin
                            r_freedv <= acc;
                        end
                    end
                    MD_MARKI: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status      <= r_status;
            o_first_frame <= r_first;
            o_freed       <= COUNT_W'(r_freedv);
            o_free_left   <= COUNT_W'(r_free);
        end
    end

endmodule

// File: rtl/cfa_ctrl.sv
module cfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  cfa_pkg::t_stat i_stat,
    output cfa_pkg::t_cmd  o_cmd
);
    import cfa_pkg::*;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_PREP = 6'b000100,
        S_RD   = 6'b001000,
        S_EV   = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_init, n_init;
    logic   r_ovalid, n_ovalid;

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_ovalid;

    // Sequencing of the map walks.
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_init    = r_init;
        n_ovalid  = r_ovalid && !i_ready;
        o_cmd     = '0;
        o_cmd.mode      = r_mode;
        o_cmd.init_fill = r_init;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_init ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_stat.pre_done) begin
                    n_state = S_OUT;
                end else if (i_stat.pre_init) begin
                    n_init  = 1'b1;
                    n_state = S_CLR;
                end else begin
                    n_mode  = i_stat.pre_mode;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EV;
            end
            S_EV: begin
                o_cmd.ev = 1'b1;
                if (i_stat.ev_done) begin
                    if (r_mode == MD_SCAN && i_stat.found) begin
                        n_mode  = MD_MARKA;
                        n_state = S_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_init         = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_mode   <= MD_SCAN;
            r_init   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_init   <= n_init;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

// File: rtl/contiguous_frame_allocator.sv
// Channel   | Direction | Handshake           | Payload
// request   | in        | i_valid / o_ready   | i_kind, i_frame_no, i_count
// result    | out       | o_valid / i_ready   | o_status, o_first_frame, o_freed, o_free_left
// config    | in        | psel/penable/pready | paddr, pwdata, prdata (APB)
//
// The frame map sits in one single-port memory of one word per FRAMES_PER_WORD frames. Each
// word visited is read in S_RD and then processed in S_EV, where every walk but the scan
// writes it back. Allocate walks from word 0 to the first fit and then over the run.
// Release and mark walk from word 0 to the end of their range; init sweeps the whole map.
// Checks that fail end a request without any map access. After reset the map is cleared
// before o_ready rises. A new request is taken while a result still waits in the output
// register.
module contiguous_frame_allocator #(
    parameter int MAX_FRAMES      = cfa_pkg::MAX_FRAMES_DEF,
    parameter int FRAMES_PER_WORD = cfa_pkg::FPW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_kind,
    input  logic [cfa_pkg::FRAME_W-1:0]   i_frame_no,
    input  logic [cfa_pkg::COUNT_W-1:0]   i_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cfa_pkg::STATUS_W-1:0]  o_status,
    output logic [cfa_pkg::FRAME_W-1:0]   o_first_frame,
    output logic [cfa_pkg::COUNT_W-1:0]   o_freed,
    output logic [cfa_pkg::COUNT_W-1:0]   o_free_left,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfa_pkg::PADDR_W-1:0]   paddr,
    input  logic [cfa_pkg::PDATA_W-1:0]   pwdata,
    output logic [cfa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import cfa_pkg::*;

    logic [FRAME_W-1:0] r_base;
    logic [COUNT_W-1:0] r_pool;
    logic               r_reserve;
    t_cmd               cmd;
    t_stat              stat;

    assign pready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_pool    <= POOL_RESET;
            r_reserve <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                RG_BASE:    r_base    <= pwdata[FRAME_W-1:0];
                RG_POOL:    r_pool    <= pwdata[COUNT_W-1:0];
                RG_RESERVE: r_reserve <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb begin
        unique case (paddr[3:2])
            RG_BASE:    prdata = PDATA_W'(r_base);
            RG_POOL:    prdata = PDATA_W'(r_pool);
            RG_RESERVE: prdata = PDATA_W'(r_reserve);
            default:    prdata = '0;
        endcase
    end

    cfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cfa_dpath #(
        .MAX_FRAMES      (MAX_FRAMES),
        .FRAMES_PER_WORD (FRAMES_PER_WORD)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_base        (r_base),
        .i_pool        (r_pool),
        .i_reserve     (r_reserve),
        .i_kind        (i_kind),
        .i_frame_no    (i_frame_no),
        .i_count       (i_count),
        .o_status      (o_status),
        .o_first_frame (o_first_frame),
        .o_freed       (o_freed),
        .o_free_left   (o_free_left)
    );

endmodule

// File: rtl/cfa_checker.sv
module cfa_assertions (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [cfa_pkg::STATUS_W-1:0]  o_status,
    input logic [cfa_pkg::FRAME_W-1:0]   o_first_frame,
    input logic [cfa_pkg::COUNT_W-1:0]   o_freed,
    input logic [cfa_pkg::COUNT_W-1:0]   o_free_left,
    input logic                          pready
);
    import cfa_pkg::*;

    // A held result keeps its status and free count until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_free_left))
        else $error("result changed while stalled");

    // Status codes stay within the defined set.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_RANGE)
        else $error("undefined status code");

    // A failed transaction reports no frame and frees nothing.
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_first_frame == '0 && o_freed == '0)
        else $error("failed transaction carries data");

    // Only one of freed frames or an allocated frame can be reported.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_freed != '0 |-> o_first_frame == '0)
        else $error("release reported a first frame");

    // The configuration port never stalls.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind contiguous_frame_allocator cfa_assertions u_cfa_assertions (.*);

// File: dv/cfa_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and configuration ports, keeps its own copy of
// the frame map and predicts every result.
module cfa_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic [1:0]                   i_kind,
    input  logic [cfa_pkg::FRAME_W-1:0]  i_frame_no,
    input  logic [cfa_pkg::COUNT_W-1:0]  i_count,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic [cfa_pkg::STATUS_W-1:0] o_status,
    input  logic [cfa_pkg::FRAME_W-1:0]  o_first_frame,
    input  logic [cfa_pkg::COUNT_W-1:0]  o_freed,
    input  logic [cfa_pkg::COUNT_W-1:0]  o_free_left,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cfa_pkg::PADDR_W-1:0]  paddr,
    input  logic [cfa_pkg::PDATA_W-1:0]  pwdata,
    input  logic                         pready,
    output int                           o_errors,
    output int                           o_pending
);
    import cfa_pkg::*;

    typedef struct {
        t_status           status;
        logic [FRAME_W-1:0] first;
        logic [COUNT_W-1:0] freed;
        logic [COUNT_W-1:0] free_left;
    } t_answer;

    logic [1:0]         frame_map [MAX_FRAMES_DEF];
    int                 free_frames;
    logic [FRAME_W-1:0] base_reg;
    logic [COUNT_W-1:0] pool_reg;
    logic               reserve_reg;
    t_answer            answers_due [$];

    assign o_pending = answers_due.size();

    function automatic int usable_frames();
        int s;
        s = pool_reg;
        if (s > MAX_FRAMES_DEF) begin
            s = MAX_FRAMES_DEF;
        end
        return s - (s % FPW_DEF);
    endfunction

    function automatic void take_free(int n);
        free_frames = (n > free_frames) ? 0 : free_frames - n;
    endfunction

    function automatic void give_free(int n);
        free_frames = free_frames + n;
        if (free_frames > MAX_FRAMES_DEF) begin
            free_frames = MAX_FRAMES_DEF;
        end
    endfunction

    // Applies one request to the local map and returns the answer it must give.
    function automatic t_answer serve_request(logic [1:0] kind,
                                              logic [FRAME_W-1:0] fno,
                                              logic [COUNT_W-1:0] cnt);
        t_answer a;
        int sz, off, run, start, n, i;
        bit found;
        sz = usable_frames();
        off = int'(fno) - int'(base_reg);
        a.status = ST_OK;
        a.first = '0;
        a.freed = '0;
        case (t_kind'(kind))
            K_ALLOC: begin
                if (cnt == 0) begin
                    a.status = ST_NORUN;
                end else if (cnt > free_frames) begin
                    a.status = ST_FEW;
                end else begin
                    run = 0;
                    start = 0;
                    found = 0;
                    for (i = 0; i < sz && !found; i++) begin
                        if (frame_map[i] != FS_FREE) begin
                            run = 0;
                        end else begin
                            if (run == 0) begin
                                start = i;
                            end
                            run++;
                            if (run == cnt) begin
                                found = 1;
                            end
                        end
                    end
                    if (!found) begin
                        a.status = ST_NORUN;
                    end else begin
                        frame_map[start] = FS_HEAD;
                        for (i = start + 1; i < start + cnt; i++) begin
                            frame_map[i] = FS_ALLOC;
                        end
                        take_free(cnt);
                        a.first = base_reg + FRAME_W'(start);
                    end
                end
            end
            K_REL: begin
                if (off < 0 || off >= sz) begin
                    a.status = ST_RANGE;
                end else if (frame_map[off] != FS_HEAD) begin
                    a.status = ST_NOTHEAD;
                end else begin
                    frame_map[off] = FS_FREE;
                    n = 1;
                    for (i = off + 1; i < sz && frame_map[i] == FS_ALLOC; i++) begin
                        frame_map[i] = FS_FREE;
                        n++;
                    end
                    give_free(n);
                    a.freed = COUNT_W'(n);
                end
            end
            K_MARK: begin
                if (off < 0 || off > sz || cnt > sz - off) begin
                    a.status = ST_RANGE;
                end else begin
                    n = 0;
                    for (i = off; i < off + cnt; i++) begin
                        if (frame_map[i] == FS_FREE) begin
                            n++;
                        end
                        frame_map[i] = FS_INACC;
                    end
                    take_free(n);
                end
            end
            default: begin
                foreach (frame_map[i]) begin
                    frame_map[i] = FS_FREE;
                end
                free_frames = sz;
                if (reserve_reg && sz > 0) begin
                    frame_map[0] = FS_HEAD;
                    free_frames--;
                end
            end
        endcase
        a.free_left = COUNT_W'(free_frames);
        return a;
    endfunction

    task automatic report(string field, int got, int want);
        $display("%0t: result %s is %0d, predicted %0d", $realtime, field, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
    end

    // Result side first: a result always belongs to an older transaction.
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (frame_map[i]) begin
                frame_map[i] = FS_FREE;
            end
            free_frames = MAX_FRAMES_DEF;
            base_reg = '0;
            pool_reg = POOL_RESET;
            reserve_reg = 1'b0;
            answers_due.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: result transaction with nothing outstanding", $realtime);
                    o_errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (o_status != want.status) report("status", o_status, want.status);
                    if (o_first_frame != want.first) begin
                        report("first_frame", o_first_frame, want.first);
                    end
                    if (o_freed != want.freed) report("freed", o_freed, want.freed);
                    if (o_free_left != want.free_left) begin
                        report("free_left", o_free_left, want.free_left);
                    end
                end
            end
            if (i_valid && o_ready) begin
                answers_due.push_back(serve_request(i_kind, i_frame_no, i_count));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    RG_BASE:    base_reg = pwdata[FRAME_W-1:0];
                    RG_POOL:    pool_reg = pwdata[COUNT_W-1:0];
                    RG_RESERVE: reserve_reg = pwdata[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import cfa_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [1:0]          i_kind;
    logic [FRAME_W-1:0]  i_frame_no;
    logic [COUNT_W-1:0]  i_count;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [FRAME_W-1:0]  o_first_frame;
    logic [COUNT_W-1:0]  o_freed;
    logic [COUNT_W-1:0]  o_free_left;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  errors;
    int                  pending;

    int                  burst_left;
    int                  kind_sent [4];
    int                  settings_used;
    int                  idle_cycles;
    logic [FRAME_W-1:0]  cur_base;
    int                  cur_frames;

    contiguous_frame_allocator i_dut (.*);

    cfa_checker i_checker (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_frame_no, .i_count,
        .o_valid, .i_ready, .o_status, .o_first_frame, .o_freed, .o_free_left,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver stalls: one of four i_ready patterns, chosen at random and redrawn as the phase advances.
    initial begin
        int stall_mode;
        int phase;
        i_ready = 1'b0;
        phase = 0;
        stall_mode = 0;
        forever begin
            @(negedge i_clk);
            if (phase % 64 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 1) == 1);
                2: i_ready <= (phase % 4 == 0);
                default: i_ready <= ($urandom_range(0, 7) != 0);
            endcase
            phase++;
        end
    end

    // Watchdog: counts cycles with no transaction on any port.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] index, logic [PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Sets all three registers; the testbench keeps the base and usable size.
    task automatic configure(logic [FRAME_W-1:0] base, logic [COUNT_W-1:0] pool, bit rsv);
        write_reg(RG_BASE, PDATA_W'(base));
        write_reg(RG_POOL, PDATA_W'(pool));
        write_reg(RG_RESERVE, PDATA_W'(rsv));
        cur_base = base;
        cur_frames = (pool > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : pool;
        cur_frames -= cur_frames % FPW_DEF;
        settings_used++;
    endtask

    // Sends one request transaction; requests go out in bursts with gaps between.
    task automatic send(t_kind kind, logic [FRAME_W-1:0] fno, logic [COUNT_W-1:0] cnt);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_frame_no <= fno;
        i_count <= cnt;
        kind_sent[kind]++;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Holds the sender until every outstanding result has come back.
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // One random request, mostly aimed inside the current pool.
    task automatic send_random();
        int pick;
        int span;
        span = (cur_frames > 0) ? cur_frames : FPW_DEF;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send(K_ALLOC, FRAME_W'($urandom),
                 ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom)
                                             : COUNT_W'($urandom_range(1, span / 3 + 1)));
        end else if (pick < 65) begin
            send(K_REL, cur_base + FRAME_W'($urandom_range(0, span - 1)), COUNT_W'($urandom));
        end else if (pick < 82) begin
            send(K_MARK, cur_base + FRAME_W'($urandom_range(0, span)),
                 COUNT_W'($urandom_range(0, 4)));
        end else if (pick < 86) begin
            send(K_INIT, FRAME_W'($urandom), COUNT_W'($urandom));
        end else begin
            send(t_kind'($urandom_range(0, 3)), FRAME_W'($urandom), COUNT_W'($urandom));
        end
    endtask

    initial begin
        logic [COUNT_W-1:0] pool;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = K_ALLOC;
        i_frame_no = '0;
        i_count = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_cycles = 0;
        burst_left = 0;
        settings_used = 1;
        cur_base = '0;
        cur_frames = MAX_FRAMES_DEF;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: whole-pool allocate, release, edges of the pool.
        send(K_ALLOC, '0, '0);
        send(K_ALLOC, '0, '1);
        send(K_ALLOC, '0, 15'd16384);
        send(K_ALLOC, '0, 15'd1);
        send(K_REL, '0, '0);
        send(K_REL, '0, '0);
        send(K_REL, '1, '0);
        send(K_MARK, 20'd16380, 15'd4);
        send(K_MARK, 20'd16383, 15'd2);
        send(K_MARK, 20'd16384, 15'd0);
        send(K_ALLOC, '0, 15'd3);
        send(K_REL, 20'd1, '0);
        drain();

        // Base near the top of the frame space: wrap of the returned frame,
        // a map left over without init, and a reserved first frame.
        configure(20'hFFFFE, 15'd7, 1'b1);
        send(K_ALLOC, '0, 15'd2);
        send(K_INIT, '0, '0);
        send(K_ALLOC, '0, 15'd3);
        send(K_REL, 20'hFFFFE, '0);
        send(K_REL, 20'h00001, '0);
        send(K_MARK, 20'hFFFFE, 15'd4);
        send(K_ALLOC, '0, 15'd1);
        drain();

        // Pool too small to manage any frame.
        configure('0, 15'd3, 1'b1);
        send(K_INIT, '0, '0);
        send(K_ALLOC, '0, 15'd1);
        send(K_MARK, '0, '0);
        send(K_REL, '0, '0);
        drain();

        // Random phases over varied settings; the last one uses the largest pool.
        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 6) begin
                pool = '1;
            end else if ($urandom_range(0, 3) == 0) begin
                pool = COUNT_W'($urandom_range(0, 12));
            end else begin
                pool = COUNT_W'($urandom_range(4, 96));
            end
            case ($urandom_range(0, 2))
                0: configure('0, pool, 1'($urandom));
                1: configure(20'hFFFFF - FRAME_W'($urandom_range(0, 40)), pool, 1'($urandom));
                default: configure(FRAME_W'($urandom), pool, 1'($urandom));
            endcase
            if ($urandom_range(0, 4) != 0) send(K_INIT, FRAME_W'($urandom), COUNT_W'($urandom));
            for (int n = 0; n < ((ph == 6) ? 8 : 18); n++) begin
                send_random();
            end
            drain();
        end

        repeat (50) @(negedge i_clk);
        $display("Sent %0d allocates, %0d releases, %0d marks and %0d inits",
                 kind_sent[K_ALLOC], kind_sent[K_REL], kind_sent[K_MARK], kind_sent[K_INIT]);
        $display("across %0d register settings, including empty, clamped and wrapping pools.",
                 settings_used);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/cfa_pkg.sv
rtl/cfa_dpath.sv
rtl/cfa_ctrl.sv
rtl/contiguous_frame_allocator.sv
rtl/cfa_checker.sv
dv/cfa_checker.sv
dv/tb.sv
